// ----- rtl/core/sgb_enc_pkg.sv -----
// Shared types, constants and table functions for the steer/gas/brake command encoder.
// Holds the inverse-radius breakpoint table and the radix-2 divider step.
// No dependencies.
package sgb_enc_pkg;

   // Breakpoint table geometry (the table contents are fixed, so is its size)
   localparam int TABLE_POINTS = 10;
   localparam int SEG_COUNT    = TABLE_POINTS - 1;
   localparam int PT_IDX_W     = $clog2(TABLE_POINTS);
   localparam int SEG_IDX_W    = $clog2(SEG_COUNT);

   // Q24 fixed point for radii and control values
   localparam int Q24_FRAC = 24;
   localparam int Q24_W    = Q24_FRAC + 2;
   localparam logic signed [Q24_W-1:0] Q24_ONE = Q24_W'(1) << Q24_FRAC;

   // Segment arithmetic widths (bounded by the fixed table)
   localparam int DEN_W          = 22;
   localparam int DC_W           = 23;
   localparam int PROD_W         = DEN_W + DC_W;
   localparam int QUO_W          = 24;
   localparam int DIV_STAGE_BITS = 2;
   localparam int DIV_STAGES     = QUO_W / DIV_STAGE_BITS;

   // Port field widths
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 16;
   localparam int BYTE_W   = 8;
   localparam int MAG_W    = 6;
   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   // Action codes double as the command code in the top two bits of the byte
   typedef enum logic [ACTION_W-1:0] {
      ACT_KILL  = 2'd0,
      ACT_STEER = 2'd1,
      ACT_GAS   = 2'd2,
      ACT_BRAKE = 2'd3
   } action_type;

   typedef struct packed {
      logic signed [Q24_W-1:0] r0;
      logic signed [Q24_W-1:0] c0;
      logic [DC_W-1:0]         dc;
      logic [DEN_W-1:0]        den;
   } seg_entry_type;

   typedef struct packed {
      action_type              action;
      logic                    below;
      logic                    above;
      logic [MAG_W-1:0]        mag;
      logic signed [Q24_W-1:0] c0;
   } side_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] plow;
      logic [QUO_W-1:0] quo;
      logic [DEN_W-1:0] den;
      side_type         side;
   } div_state_type;

   // Measured inverse-radius breakpoints, Q24
   function automatic logic signed [Q24_W-1:0] radius_q24(input logic [PT_IDX_W-1:0] idx);
      logic signed [Q24_W-1:0] r;
      unique case (idx)
         4'd0:    r = Q24_W'(-8052883);
         4'd1:    r = Q24_W'(-6682118);
         4'd2:    r = Q24_W'(-4962466);
         4'd3:    r = Q24_W'(-2716239);
         4'd4:    r = Q24_W'(-2181006);
         4'd5:    r = Q24_W'(1476562);
         4'd6:    r = Q24_W'(3081535);
         4'd7:    r = Q24_W'(5741728);
         4'd8:    r = Q24_W'(7248224);
         4'd9:    r = Q24_W'(8952317);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Control values at the breakpoints, Q24
   function automatic logic signed [Q24_W-1:0] ctrl_q24(input logic [PT_IDX_W-1:0] idx);
      logic signed [Q24_W-1:0] c;
      unique case (idx)
         4'd0:    c = Q24_W'(-16777216);
         4'd1:    c = Q24_W'(-12516336);
         4'd2:    c = Q24_W'(-8255455);
         4'd3:    c = Q24_W'(-3994575);
         4'd4:    c = Q24_W'(-1864135);
         4'd5:    c = Q24_W'(2396745);
         4'd6:    c = Q24_W'(4527185);
         4'd7:    c = Q24_W'(8788066);
         4'd8:    c = Q24_W'(13048946);
         4'd9:    c = Q24_W'(16777216);
         default: c = '0;
      endcase
      return c;
   endfunction

   // One segment: start point, start value, rise and run
   function automatic seg_entry_type seg_entry(input logic [SEG_IDX_W-1:0] idx);
      logic [PT_IDX_W-1:0]     lo;
      logic [PT_IDX_W-1:0]     hi;
      logic signed [Q24_W-1:0] r1;
      logic signed [Q24_W-1:0] c1;
      seg_entry_type           e;
      lo    = PT_IDX_W'(idx);
      hi    = lo + PT_IDX_W'(1);
      e.r0  = radius_q24(lo);
      e.c0  = ctrl_q24(lo);
      r1    = radius_q24(hi);
      c1    = ctrl_q24(hi);
      e.dc  = DC_W'(c1 - e.c0);
      e.den = DEN_W'(r1 - e.r0);
      return e;
   endfunction

   // Restoring division: retire DIV_STAGE_BITS quotient bits
   function automatic div_state_type div_steps(input div_state_type s);
      div_state_type  o;
      logic [DEN_W:0] t;
      o = s;
      for (int k = 0; k < DIV_STAGE_BITS; k++) begin
         t      = {o.rem, o.plow[QUO_W-1]};
         o.plow = {o.plow[QUO_W-2:0], 1'b0};
         if (t >= {1'b0, o.den}) begin
            o.rem = DEN_W'(t - {1'b0, o.den});
            o.quo = {o.quo[QUO_W-2:0], 1'b1};
         end else begin
            o.rem = t[DEN_W-1:0];
            o.quo = {o.quo[QUO_W-2:0], 1'b0};
         end
      end
      return o;
   endfunction

endpackage

// ----- rtl/core/sgb_enc_seg_rom.sv -----
// Segment coefficient ROM with registered read.
// Depends on sgb_enc_pkg (seg_entry table function).
module sgb_enc_seg_rom import sgb_enc_pkg::*; (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [SEG_IDX_W-1:0] rd_addr,
   output seg_entry_type        rd_data
);

   seg_entry_type rd_data_ff;

   // Hold the read word while the consuming stage is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= seg_entry(rd_addr);
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sgb_enc_div_pipe.sv -----
// Pipelined restoring divider, DIV_STAGE_BITS quotient bits per stage.
// Depends on sgb_enc_pkg (div_state_type, div_steps).
module sgb_enc_div_pipe import sgb_enc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [PROD_W-1:0] in_prod,
   input  logic [DEN_W-1:0]  in_den,
   input  side_type          in_side,
   output logic              in_en,
   output logic              out_valid,
   output div_state_type     out_state,
   input  logic              out_en
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_in;
   logic [DIV_STAGES-1:0] en;
   div_state_type         state_ff [DIV_STAGES];
   div_state_type         state_in [DIV_STAGES];
   div_state_type         start;

   // Upper dividend bits seed the remainder, the rest shift in one per step
   always_comb begin
      start      = '0;
      start.rem  = DEN_W'(in_prod[PROD_W-1:QUO_W]);
      start.plow = in_prod[QUO_W-1:0];
      start.den  = in_den;
      start.side = in_side;
   end

   // A stage advances when it is empty or its successor advances
   always_comb begin
      en[DIV_STAGES-1] = !valid_ff[DIV_STAGES-1] || out_en;
      for (int s = DIV_STAGES - 2; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      if (g == 0) begin : g_first
         always_comb begin
            valid_in[g] = in_valid;
            state_in[g] = div_steps(start);
         end
      end else begin : g_rest
         always_comb begin
            valid_in[g] = valid_ff[g-1];
            state_in[g] = div_steps(state_ff[g-1]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en[g]) begin
            valid_ff[g] <= valid_in[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en[g]) begin
            state_ff[g] <= state_in[g];
         end
      end
   end

   assign in_en     = en[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_state = state_ff[DIV_STAGES-1];

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_state.side.action == ACT_STEER
      && !out_state.side.below && !out_state.side.above
      |-> out_state.rem < out_state.den)
      else $error("divider remainder not below divisor");

   a_full_on_stall: assert property (@(posedge clock) disable iff (reset)
      !in_en |-> &valid_ff)
      else $error("divider refuses input with a free stage");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_en |=> out_valid)
      else $error("divider dropped a held result");

endmodule

// ----- rtl/core/steer_gas_brake_command_encoder.sv -----
// Top level of the steer/gas/brake command encoder: input decode, segment ROM,
// slope multiply, divider pipeline and output register.
// Depends on sgb_enc_pkg, sgb_enc_seg_rom and sgb_enc_div_pipe.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------
//   req     | in        | req_valid/req_stall  | req_action, req_value
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_control_byte
//
// One request per cycle sustained while rsp_stall is low; each result passes through
// decode/ROM, offset, multiply, DIV_STAGES = 12 divider stages at two quotient bits
// each, then the byte in the output register.
// Reset clears the stage valid bits only; the ROM is constant and needs none.
// Each stage advances when it is empty or the next one advances, so a held
// result only backs up the pipe once every stage is occupied.
module steer_gas_brake_command_encoder import sgb_enc_pkg::*; #(
   parameter int FRACTION_BITS = 15
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [BYTE_W-1:0]         rsp_control_byte
);

   // Input scaled to Q24; wide enough for the shifted value and the table
   localparam int X_SHIFT  = Q24_FRAC - FRACTION_BITS;
   localparam int X_W      = (VALUE_W + X_SHIFT > Q24_W) ? VALUE_W + X_SHIFT : Q24_W;
   // Intensity compare width: holds the value and 2^FRACTION_BITS
   localparam int CMP_W    = (FRACTION_BITS + 2 > VALUE_W + 1) ? FRACTION_BITS + 2 : VALUE_W + 1;
   localparam int PROD_G_W = CMP_W + MAG_W;
   localparam int STEER_W  = Q24_W + MAG_W;

   // ---------------------------------------------------------------------
   // Decode: scale, locate the segment, work out gas and brake magnitudes
   // ---------------------------------------------------------------------
   action_type              req_act;
   logic signed [X_W-1:0]   a_x_in;
   logic signed [X_W-1:0]   rad_x [TABLE_POINTS];
   logic [TABLE_POINTS-1:0] ge;
   logic [SEG_IDX_W-1:0]    seg_idx;
   logic signed [CMP_W-1:0] v_ext;
   logic signed [CMP_W-1:0] one_c;
   logic signed [CMP_W-1:0] vc;
   logic [PROD_G_W-1:0]     gas_base;
   logic [PROD_G_W-1:0]     brake_base;
   logic [PROD_G_W-1:0]     gas_prod;
   logic [PROD_G_W-1:0]     brake_prod;
   side_type                a_side_in;

   always_comb begin
      req_act = action_type'(req_action);
      a_x_in  = {{(X_W-VALUE_W){req_value[VALUE_W-1]}}, req_value};
      a_x_in  = a_x_in <<< X_SHIFT;

      // Thermometer of breakpoints at or below x; the later segment wins on a hit
      for (int j = 0; j < TABLE_POINTS; j++) begin
         rad_x[j] = X_W'(radius_q24(PT_IDX_W'(j)));
         ge[j]    = a_x_in >= rad_x[j];
      end
      seg_idx = '0;
      for (int j = 1; j < SEG_COUNT; j++) begin
         if (ge[j]) begin
            seg_idx = SEG_IDX_W'(j);
         end
      end

      // Clamp intensity to 0..1, then scale by 63 as a shift-subtract
      v_ext = {{(CMP_W-VALUE_W){req_value[VALUE_W-1]}}, req_value};
      one_c = CMP_W'(1) << FRACTION_BITS;
      priority if (v_ext < 0) begin
         vc = '0;
      end else if (v_ext > one_c) begin
         vc = one_c;
      end else begin
         vc = v_ext;
      end
      gas_base   = PROD_G_W'(one_c - vc);
      brake_base = PROD_G_W'(vc);
      gas_prod   = (gas_base << MAG_W) - gas_base;
      brake_prod = (brake_base << MAG_W) - brake_base;

      a_side_in        = '0;
      a_side_in.action = req_act;
      a_side_in.below  = !ge[0];
      a_side_in.above  = a_x_in > rad_x[TABLE_POINTS-1];
      unique case (req_act)
         ACT_KILL:  a_side_in.mag = '0;
         ACT_STEER: a_side_in.mag = '0;
         ACT_GAS:   a_side_in.mag = gas_prod[FRACTION_BITS +: MAG_W];
         ACT_BRAKE: a_side_in.mag = brake_prod[FRACTION_BITS +: MAG_W];
         default:   a_side_in.mag = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Stage enables: advance when empty or when the successor advances
   // ---------------------------------------------------------------------
   logic          a_valid_ff;
   logic          b_valid_ff;
   logic          c_valid_ff;
   logic          rsp_valid_ff;
   logic          en_a;
   logic          en_b;
   logic          en_c;
   logic          en_e;
   logic          div_in_en;
   logic          div_valid;
   div_state_type div_out;

   assign en_e = !rsp_valid_ff || !rsp_stall;
   assign en_c = !c_valid_ff || div_in_en;
   assign en_b = !b_valid_ff || en_c;
   assign en_a = !a_valid_ff || en_b;

   assign req_stall = !en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_valid_ff <= req_valid;
         end
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (en_c) begin
            c_valid_ff <= b_valid_ff;
         end
         if (en_e) begin
            rsp_valid_ff <= div_valid;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: decoded request plus ROM read of the segment coefficients
   // ---------------------------------------------------------------------
   logic signed [X_W-1:0] a_x_ff;
   side_type              a_side_ff;
   seg_entry_type         rom_data;

   sgb_enc_seg_rom u_seg_rom (
      .clock   (clock),
      .rd_en   (en_a),
      .rd_addr (seg_idx),
      .rd_data (rom_data)
   );

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_x_ff    <= a_x_in;
         a_side_ff <= a_side_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage B: offset into the segment
   // ---------------------------------------------------------------------
   logic [DEN_W-1:0] b_n_in;
   logic [DEN_W-1:0] b_n_ff;
   logic [DC_W-1:0]  b_dc_ff;
   logic [DEN_W-1:0] b_den_ff;
   side_type         b_side_in;
   side_type         b_side_ff;

   always_comb begin
      b_n_in       = DEN_W'(a_x_ff - X_W'(rom_data.r0));
      b_side_in    = a_side_ff;
      b_side_in.c0 = rom_data.c0;
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_n_ff    <= b_n_in;
         b_dc_ff   <= rom_data.dc;
         b_den_ff  <= rom_data.den;
         b_side_ff <= b_side_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage C: offset times rise
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0] c_prod_in;
   logic [PROD_W-1:0] c_prod_ff;
   logic [DEN_W-1:0]  c_den_ff;
   side_type          c_side_ff;

   assign c_prod_in = PROD_W'(b_n_ff) * PROD_W'(b_dc_ff);

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_prod_ff <= c_prod_in;
         c_den_ff  <= b_den_ff;
         c_side_ff <= b_side_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Divide by the run of the segment
   // ---------------------------------------------------------------------
   sgb_enc_div_pipe u_div_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_prod   (c_prod_ff),
      .in_den    (c_den_ff),
      .in_side   (c_side_ff),
      .in_en     (div_in_en),
      .out_valid (div_valid),
      .out_state (div_out),
      .out_en    (en_e)
   );

   // ---------------------------------------------------------------------
   // Output: control value to steer magnitude, then assemble the byte
   // ---------------------------------------------------------------------
   logic signed [Q24_W-1:0] ctrl_val;
   logic [Q24_W-1:0]        ctrl_pos;
   logic [STEER_W-1:0]      steer_prod;
   logic [MAG_W-1:0]        steer_mag;
   logic [MAG_W-1:0]        mag_sel;
   logic [BYTE_W-1:0]       rsp_byte_in;
   logic [BYTE_W-1:0]       rsp_byte_ff;

   always_comb begin
      ctrl_val   = div_out.side.c0 + $signed({{(Q24_W-QUO_W){1'b0}}, div_out.quo});
      ctrl_pos   = Q24_W'(ctrl_val + Q24_ONE);
      steer_prod = (STEER_W'(ctrl_pos) << MAG_W) - STEER_W'(ctrl_pos);
      // Outside the table, pin to the first or last control value
      priority if (div_out.side.below) begin
         steer_mag = '0;
      end else if (div_out.side.above) begin
         steer_mag = MAG_MAX;
      end else begin
         steer_mag = steer_prod[Q24_FRAC+1 +: MAG_W];
      end
      mag_sel     = (div_out.side.action == ACT_STEER) ? steer_mag : div_out.side.mag;
      rsp_byte_in = {div_out.side.action, mag_sel};
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         rsp_byte_ff <= rsp_byte_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_control_byte = rsp_byte_ff;

   a_kill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && action_type'(rsp_control_byte[BYTE_W-1 -: ACTION_W]) == ACT_KILL
      |-> rsp_control_byte[MAG_W-1:0] == '0)
      else $error("kill command carries a nonzero magnitude");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff && b_valid_ff && c_valid_ff)
      else $error("request stalled with a free front stage");

   a_no_stall_empty_out: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("request stalled while the output register is empty");

endmodule

// ----- tb/sv/tb_steer_gas_brake_command_encoder.sv -----
// Self-checking bench for steer_gas_brake_command_encoder: directed and random requests
// under random valid/stall idling, each output byte checked against an in-bench encoder.
// Depends on sgb_enc_pkg and the encoder RTL.
module tb_steer_gas_brake_command_encoder import sgb_enc_pkg::*;;

   localparam int VALUE_FRAC   = 15;   // Q1.15 request values
   localparam int Q24_SHIFT    = 24;   // table and control value precision
   localparam int RANDOM_COUNT = 450;

   // Expected command bytes in request order, plus the encoder that produces them
   class command_byte_board;
      logic [BYTE_W-1:0] expected_bytes[$];
      int                mismatch_count;

      // Measured inverse-radius breakpoints, Q24
      function longint inv_radius_q24(int idx);
         case (idx)
            0:       return -8052883;
            1:       return -6682118;
            2:       return -4962466;
            3:       return -2716239;
            4:       return -2181006;
            5:       return 1476562;
            6:       return 3081535;
            7:       return 5741728;
            8:       return 7248224;
            default: return 8952317;
         endcase
      endfunction

      // Control value at each breakpoint, Q24
      function longint steer_ctrl_q24(int idx);
         case (idx)
            0:       return -16777216;
            1:       return -12516336;
            2:       return -8255455;
            3:       return -3994575;
            4:       return -1864135;
            5:       return 2396745;
            6:       return 4527185;
            7:       return 8788066;
            8:       return 13048946;
            default: return 16777216;
         endcase
      endfunction

      // Interpolate the control value for an inverse radius and scale it to six bits
      function logic [MAG_W-1:0] steer_magnitude(logic signed [VALUE_W-1:0] value);
         longint x;
         longint r0;
         longint r1;
         longint c0;
         longint c1;
         longint ctrl;
         longint unit;
         bit     hit;
         unit = longint'(1) << Q24_SHIFT;
         x    = longint'(value) * (longint'(1) << (Q24_SHIFT - VALUE_FRAC));
         ctrl = 0;
         hit  = 1'b0;
         // later segments win on a shared breakpoint; both give the same value
         for (int i = 0; i + 1 < TABLE_POINTS; i++) begin
            r0 = inv_radius_q24(i);
            r1 = inv_radius_q24(i + 1);
            c0 = steer_ctrl_q24(i);
            c1 = steer_ctrl_q24(i + 1);
            if (x >= r0 && x <= r1) begin
               ctrl = c0;
               if (r1 - r0 > 0 && c1 - c0 >= 0)
                  ctrl += ((x - r0) * (c1 - c0)) / (r1 - r0);
               hit = 1'b1;
            end
         end
         if (!hit)
            ctrl = (x < inv_radius_q24(0)) ? steer_ctrl_q24(0) : steer_ctrl_q24(TABLE_POINTS - 1);
         if (ctrl < -unit) ctrl = -unit;
         if (ctrl > unit) ctrl = unit;
         return MAG_W'(((ctrl + unit) * 63) >> (Q24_SHIFT + 1));
      endfunction

      function logic [BYTE_W-1:0] encode_command(action_type act,
                                                 logic signed [VALUE_W-1:0] value);
         longint           unit;
         longint           level;
         logic [MAG_W-1:0] mag;
         unit  = longint'(1) << VALUE_FRAC;
         level = longint'(value);
         if (level < 0) level = 0;
         if (level > unit) level = unit;
         case (act)
            ACT_STEER: mag = steer_magnitude(value);
            ACT_GAS:   mag = MAG_W'(((unit - level) * 63) >> VALUE_FRAC);
            ACT_BRAKE: mag = MAG_W'((level * 63) >> VALUE_FRAC);
            default:   mag = '0;
         endcase
         return {act, mag};
      endfunction

      function void note_request(action_type act, logic signed [VALUE_W-1:0] value);
         expected_bytes = {expected_bytes, encode_command(act, value)};
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH: %s", what);
         mismatch_count++;
      endtask

      task check_byte(logic [BYTE_W-1:0] got);
         logic [BYTE_W-1:0] want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("control byte 0x%02h with no request outstanding", got));
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want)
               report_mismatch($sformatf("control byte 0x%02h, expected 0x%02h", got, want));
         end
      endtask
   endclass

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   action_type                req_action = ACT_KILL;
   logic signed [VALUE_W-1:0] req_value  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall  = 1'b0;
   logic [BYTE_W-1:0]         rsp_control_byte;

   command_byte_board board = new();

   // Calm stretches: while a counter runs down, that side never idles
   int sender_calm   = 0;
   int receiver_calm = 0;

   steer_gas_brake_command_encoder #(
      .FRACTION_BITS(VALUE_FRAC)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_control_byte (rsp_control_byte)
   );

   always #10 clock = ~clock;

   // Draw the idle cycles ahead of one transfer: none during a calm stretch, else a uniform
   // random draw; now and then open a new calm stretch
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0)
         calm_left = $urandom_range(10, 40);
      return $urandom_range(0, 4);
   endfunction

   // Present one request after a random gap and hold it until the block takes it.
   // Valid stays high into the next request when that one has no gap, so it is
   // never dropped and raised again in one step.
   task automatic send_request(action_type act, logic signed [VALUE_W-1:0] value);
      int gap;
      gap = draw_wait(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= value;
      do @(posedge clock); while (req_stall);
      board.note_request(act, value);
   endtask

   // Drop valid and hold off until every expected byte has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Stimulus: directed corners, then random requests with a full drain halfway
   initial begin
      logic signed [VALUE_W-1:0] value;
      action_type                act;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // kill ignores the value
      send_request(ACT_KILL, 16'h0000);
      send_request(ACT_KILL, 16'hFFFF);
      // steer below and above the table, at zero and just under it
      send_request(ACT_STEER, 16'h8000);
      send_request(ACT_STEER, 16'h7FFF);
      send_request(ACT_STEER, 16'h0000);
      send_request(ACT_STEER, 16'hFFFF);
      // steer right at or just below every breakpoint
      for (int i = 0; i < TABLE_POINTS; i++)
         send_request(ACT_STEER,
                      VALUE_W'(board.inv_radius_q24(i) >>> (Q24_SHIFT - VALUE_FRAC)));
      // gas and brake: negative intensity clamps to zero, then zero, half and just under full scale
      send_request(ACT_GAS, 16'h8000);
      send_request(ACT_GAS, 16'h0000);
      send_request(ACT_GAS, 16'h4000);
      send_request(ACT_GAS, 16'h7FFF);
      send_request(ACT_BRAKE, 16'h8000);
      send_request(ACT_BRAKE, 16'h0000);
      send_request(ACT_BRAKE, 16'h4000);
      send_request(ACT_BRAKE, 16'h7FFF);
      drain_responses();

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == RANDOM_COUNT / 2)
            drain_responses();
         case ($urandom_range(0, 3))
            0, 1: value = VALUE_W'($urandom_range(0, 65535));
            // concentrate on the span of the breakpoint table
            2:    value = VALUE_W'($urandom_range(0, 33215) - 15729);
            default: begin
               case ($urandom_range(0, 5))
                  0:       value = 16'h0000;
                  1:       value = 16'h0001;
                  2:       value = 16'hFFFF;
                  3:       value = 16'h7FFF;
                  4:       value = 16'h8000;
                  default: value = 16'h4000;
               endcase
            end
         endcase
         act = action_type'($urandom_range(0, 3));
         send_request(act, value);
      end

      drain_responses();
      // leave room for any stray byte past the end of the pipe
      repeat (20) @(posedge clock);
      if (board.mismatch_count == 0)
         $display("tb_steer_gas_brake_command_encoder passed");
      else
         $display("tb_steer_gas_brake_command_encoder failed");
      $finish;
   end

   // Result side: stall a random number of cycles, then take the next byte
   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_wait(receiver_calm);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.check_byte(rsp_control_byte);
      end
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb_steer_gas_brake_command_encoder failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/sgb_enc_pkg.sv
rtl/core/sgb_enc_seg_rom.sv
rtl/core/sgb_enc_div_pipe.sv
rtl/core/steer_gas_brake_command_encoder.sv
tb/sv/tb_steer_gas_brake_command_encoder.sv
